// ===== hdl/circ_pkg.sv =====
// Shared constants and types for the three-point circle pipeline.
// Used by every module under circle_through_three_points_top; depends on nothing.
package circ_pkg;

   localparam int IW  = 16;          // port field width of one coordinate
   localparam int CW  = 16;          // coordinate bits actually used
   localparam int FW  = 8;           // fraction bits of the results
   localparam int VW  = 32;          // result field width
   localparam int BW  = CW + 1;      // point differences
   localparam int PW  = 2 * BW;      // products of differences
   localparam int KW  = PW + 1;      // determinant
   localparam int NPW = BW + PW + 1; // difference times squared length
   localparam int NMW = NPW + 1;     // centre numerators
   localparam int NW  = NMW + FW + 2;// scaled dividend with rounding term
   localparam int DW  = KW + 2;      // divisor, four times the determinant
   localparam int RW  = DW + 1;      // partial remainder
   localparam int QB  = 41;          // quotient bits; the top one flags overflow
   localparam int OW  = QB + 1;      // signed centre offset
   localparam int CXW = OW + 1;      // centre before clipping
   localparam int MW  = 33;          // offset magnitude allowed into the radius
   localparam int RB  = 35;          // square root result bits
   localparam int SQW = 2 * RB;      // square root remainder

   typedef struct packed {
      logic [IW-1:0] third_y;
      logic [IW-1:0] third_x;
      logic [IW-1:0] second_y;
      logic [IW-1:0] second_x;
      logic [IW-1:0] first_y;
      logic [IW-1:0] first_x;
   } point_set_type;

   typedef struct packed {
      logic signed [CW-1:0] x1;
      logic signed [CW-1:0] y1;
      logic                 coll;
   } side_type;

   typedef struct packed {
      logic [NW-1:0] num_x;
      logic [NW-1:0] num_y;
      logic [DW-1:0] den;
      logic          neg_x;
      logic          neg_y;
      side_type      side;
   } div_in_type;

   typedef struct packed {
      logic [QB-1:0] q_x;
      logic [QB-1:0] q_y;
      logic          big_x;
      logic          big_y;
      logic          neg_x;
      logic          neg_y;
      side_type      side;
   } div_out_type;

   typedef struct packed {
      logic [RW-1:0] rem;
      logic [QB-1:0] bits;
      logic [QB-1:0] q;
      logic          big;
      logic          neg;
   } div_lane_type;

   typedef struct packed {
      div_lane_type  lx;
      div_lane_type  ly;
      logic [DW-1:0] den;
      side_type      side;
   } div_stage_type;

   typedef struct packed {
      logic [SQW-1:0] rem;
      logic [RB-1:0]  root;
      logic [VW-1:0]  cx;
      logic [VW-1:0]  cy;
      logic           satc;
      logic           ovf;
      logic           coll;
   } root_stage_type;

   typedef struct packed {
      logic          saturated;
      logic          collinear;
      logic [VW-1:0] radius;
      logic [VW-1:0] center_y;
      logic [VW-1:0] center_x;
   } result_type;

endpackage

// ===== hdl/circ_front.sv =====
// Front stages: point differences, determinant, squared lengths and centre numerators.
// Produces the dividend and divisor for circ_div; depends on circ_pkg.
module circ_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  circ_pkg::point_set_type in_pts,
   output logic                    out_valid,
   output circ_pkg::div_in_type    out_data
);

   logic [5:0] v_ff;

   logic signed [circ_pkg::CW-1:0]  x1_in, y1_in, x2_in, y2_in, x3_in, y3_in;
   logic signed [circ_pkg::CW-1:0]  x1_s1_ff, y1_s1_ff, x1_s2_ff, y1_s2_ff;
   logic signed [circ_pkg::CW-1:0]  x1_s3_ff, y1_s3_ff, x1_s4_ff, y1_s4_ff;
   logic signed [circ_pkg::CW-1:0]  x1_s5_ff, y1_s5_ff;
   logic signed [circ_pkg::BW-1:0]  bx_s1_ff, by_s1_ff, qx_s1_ff, qy_s1_ff;
   logic signed [circ_pkg::BW-1:0]  bx_s2_ff, by_s2_ff, qx_s2_ff, qy_s2_ff;
   logic signed [circ_pkg::BW-1:0]  bx_s3_ff, by_s3_ff, qx_s3_ff, qy_s3_ff;
   logic signed [circ_pkg::PW-1:0]  pa_s2_ff, pb_s2_ff;
   logic signed [circ_pkg::PW-1:0]  sbx_s2_ff, sby_s2_ff, sqx_s2_ff, sqy_s2_ff;
   logic [circ_pkg::KW-1:0]         k_s3_ff;
   logic [circ_pkg::PW-1:0]         bb_s3_ff, cc_s3_ff;
   logic signed [circ_pkg::NPW-1:0] m1_s4_ff, m2_s4_ff, m3_s4_ff, m4_s4_ff;
   logic [circ_pkg::KW-1:0]         kmag_s4_ff, kmag_s5_ff;
   logic                            kneg_s4_ff, kneg_s5_ff, coll_s4_ff, coll_s5_ff;
   logic [circ_pkg::NMW-1:0]        nx_s5_ff, ny_s5_ff;
   logic [circ_pkg::NMW-1:0]        magx_in, magy_in;
   circ_pkg::div_in_type            out_in, out_ff;

   assign x1_in = $signed(in_pts.first_x[circ_pkg::CW-1:0]);
   assign y1_in = $signed(in_pts.first_y[circ_pkg::CW-1:0]);
   assign x2_in = $signed(in_pts.second_x[circ_pkg::CW-1:0]);
   assign y2_in = $signed(in_pts.second_y[circ_pkg::CW-1:0]);
   assign x3_in = $signed(in_pts.third_x[circ_pkg::CW-1:0]);
   assign y3_in = $signed(in_pts.third_y[circ_pkg::CW-1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[4:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x1_s1_ff <= x1_in;
         y1_s1_ff <= y1_in;
         bx_s1_ff <= $signed({x2_in[circ_pkg::CW-1], x2_in}) - $signed({x1_in[circ_pkg::CW-1], x1_in});
         by_s1_ff <= $signed({y2_in[circ_pkg::CW-1], y2_in}) - $signed({y1_in[circ_pkg::CW-1], y1_in});
         qx_s1_ff <= $signed({x3_in[circ_pkg::CW-1], x3_in}) - $signed({x1_in[circ_pkg::CW-1], x1_in});
         qy_s1_ff <= $signed({y3_in[circ_pkg::CW-1], y3_in}) - $signed({y1_in[circ_pkg::CW-1], y1_in});

         x1_s2_ff  <= x1_s1_ff;
         y1_s2_ff  <= y1_s1_ff;
         bx_s2_ff  <= bx_s1_ff;
         by_s2_ff  <= by_s1_ff;
         qx_s2_ff  <= qx_s1_ff;
         qy_s2_ff  <= qy_s1_ff;
         pa_s2_ff  <= bx_s1_ff * qy_s1_ff;
         pb_s2_ff  <= by_s1_ff * qx_s1_ff;
         sbx_s2_ff <= bx_s1_ff * bx_s1_ff;
         sby_s2_ff <= by_s1_ff * by_s1_ff;
         sqx_s2_ff <= qx_s1_ff * qx_s1_ff;
         sqy_s2_ff <= qy_s1_ff * qy_s1_ff;

         x1_s3_ff <= x1_s2_ff;
         y1_s3_ff <= y1_s2_ff;
         bx_s3_ff <= bx_s2_ff;
         by_s3_ff <= by_s2_ff;
         qx_s3_ff <= qx_s2_ff;
         qy_s3_ff <= qy_s2_ff;
         k_s3_ff  <= {pa_s2_ff[circ_pkg::PW-1], pa_s2_ff} - {pb_s2_ff[circ_pkg::PW-1], pb_s2_ff};
         bb_s3_ff <= {1'b0, sbx_s2_ff[circ_pkg::PW-2:0]} + {1'b0, sby_s2_ff[circ_pkg::PW-2:0]};
         cc_s3_ff <= {1'b0, sqx_s2_ff[circ_pkg::PW-2:0]} + {1'b0, sqy_s2_ff[circ_pkg::PW-2:0]};

         x1_s4_ff   <= x1_s3_ff;
         y1_s4_ff   <= y1_s3_ff;
         m1_s4_ff   <= qy_s3_ff * $signed({1'b0, bb_s3_ff});
         m2_s4_ff   <= by_s3_ff * $signed({1'b0, cc_s3_ff});
         m3_s4_ff   <= bx_s3_ff * $signed({1'b0, cc_s3_ff});
         m4_s4_ff   <= qx_s3_ff * $signed({1'b0, bb_s3_ff});
         kmag_s4_ff <= k_s3_ff[circ_pkg::KW-1] ? (~k_s3_ff + 1'b1) : k_s3_ff;
         kneg_s4_ff <= k_s3_ff[circ_pkg::KW-1];
         coll_s4_ff <= (k_s3_ff == '0);

         x1_s5_ff   <= x1_s4_ff;
         y1_s5_ff   <= y1_s4_ff;
         kmag_s5_ff <= kmag_s4_ff;
         kneg_s5_ff <= kneg_s4_ff;
         coll_s5_ff <= coll_s4_ff;
         nx_s5_ff   <= {m1_s4_ff[circ_pkg::NPW-1], m1_s4_ff} - {m2_s4_ff[circ_pkg::NPW-1], m2_s4_ff};
         ny_s5_ff   <= {m3_s4_ff[circ_pkg::NPW-1], m3_s4_ff} - {m4_s4_ff[circ_pkg::NPW-1], m4_s4_ff};

         out_ff <= out_in;
      end
   end

   always_comb begin
      magx_in = nx_s5_ff[circ_pkg::NMW-1] ? (~nx_s5_ff + 1'b1) : nx_s5_ff;
      magy_in = ny_s5_ff[circ_pkg::NMW-1] ? (~ny_s5_ff + 1'b1) : ny_s5_ff;
      out_in.num_x = {1'b0, magx_in, {(circ_pkg::FW + 1){1'b0}}}
                   + {{(circ_pkg::NW - circ_pkg::KW - 1){1'b0}}, kmag_s5_ff, 1'b0};
      out_in.num_y = {1'b0, magy_in, {(circ_pkg::FW + 1){1'b0}}}
                   + {{(circ_pkg::NW - circ_pkg::KW - 1){1'b0}}, kmag_s5_ff, 1'b0};
      out_in.den       = {kmag_s5_ff, 2'b00};
      out_in.neg_x     = nx_s5_ff[circ_pkg::NMW-1] ^ kneg_s5_ff;
      out_in.neg_y     = ny_s5_ff[circ_pkg::NMW-1] ^ kneg_s5_ff;
      out_in.side.x1   = x1_s5_ff;
      out_in.side.y1   = y1_s5_ff;
      out_in.side.coll = coll_s5_ff;
   end

   assign out_valid = v_ff[5];
   assign out_data  = out_ff;

endmodule

// ===== hdl/circ_div.sv =====
// Pipelined restoring divider for both centre offsets, one quotient bit per stage.
// Takes circ_front output, feeds circ_root; depends on circ_pkg.
module circ_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  circ_pkg::div_in_type  in_data,
   output logic                  out_valid,
   output circ_pkg::div_out_type out_data
);

   circ_pkg::div_stage_type st_ff [0:circ_pkg::QB];
   circ_pkg::div_stage_type st0_in;
   logic [circ_pkg::QB:0]   v_ff;

   function automatic circ_pkg::div_lane_type lane_init(input logic [circ_pkg::NW-1:0] num,
                                                        input logic [circ_pkg::DW-1:0] den,
                                                        input logic neg);
      circ_pkg::div_lane_type l;
      logic [circ_pkg::RW-1:0] head;
      head   = {{(circ_pkg::RW - (circ_pkg::NW - circ_pkg::QB)){1'b0}},
                num[circ_pkg::NW-1:circ_pkg::QB]};
      l.big  = (head >= {1'b0, den});
      l.rem  = l.big ? '0 : head;
      l.bits = num[circ_pkg::QB-1:0];
      l.q    = '0;
      l.neg  = neg;
      return l;
   endfunction

   function automatic circ_pkg::div_lane_type lane_step(input circ_pkg::div_lane_type l,
                                                        input logic [circ_pkg::DW-1:0] den);
      logic [circ_pkg::RW-1:0] t;
      logic fit;
      t      = {l.rem[circ_pkg::RW-2:0], l.bits[circ_pkg::QB-1]};
      fit    = (t >= {1'b0, den});
      l.rem  = fit ? (t - {1'b0, den}) : t;
      l.bits = {l.bits[circ_pkg::QB-2:0], 1'b0};
      l.q    = {l.q[circ_pkg::QB-2:0], fit};
      return l;
   endfunction

   always_comb begin
      st0_in.lx   = lane_init(in_data.num_x, in_data.den, in_data.neg_x);
      st0_in.ly   = lane_init(in_data.num_y, in_data.den, in_data.neg_y);
      st0_in.den  = in_data.den;
      st0_in.side = in_data.side;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[circ_pkg::QB-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff[0] <= st0_in;
      end
   end

   for (genvar i = 1; i <= circ_pkg::QB; i++) begin : g_step
      always_ff @(posedge clock) begin
         if (en) begin
            st_ff[i].lx   <= lane_step(st_ff[i-1].lx, st_ff[i-1].den);
            st_ff[i].ly   <= lane_step(st_ff[i-1].ly, st_ff[i-1].den);
            st_ff[i].den  <= st_ff[i-1].den;
            st_ff[i].side <= st_ff[i-1].side;
         end
      end
   end

   assign out_valid      = v_ff[circ_pkg::QB];
   assign out_data.q_x   = st_ff[circ_pkg::QB].lx.q;
   assign out_data.q_y   = st_ff[circ_pkg::QB].ly.q;
   assign out_data.big_x = st_ff[circ_pkg::QB].lx.big;
   assign out_data.big_y = st_ff[circ_pkg::QB].ly.big;
   assign out_data.neg_x = st_ff[circ_pkg::QB].lx.neg;
   assign out_data.neg_y = st_ff[circ_pkg::QB].ly.neg;
   assign out_data.side  = st_ff[circ_pkg::QB].side;

endmodule

// ===== hdl/circ_root.sv =====
// Back stages: centre assembly and clipping, squared radius and pipelined square root.
// Takes circ_div output and holds the result register; depends on circ_pkg.
module circ_root (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  circ_pkg::div_out_type in_data,
   output logic                  out_valid,
   output circ_pkg::result_type  out_data
);

   localparam int NV = circ_pkg::RB + 4;

   logic [NV-1:0] v_ff;

   logic                             bigx_in, bigy_in;
   logic [circ_pkg::QB-1:0]          fullx_in, fully_in;
   logic signed [circ_pkg::OW-1:0]   ox_in, oy_in;
   logic signed [circ_pkg::CXW-1:0]  cx_in, cy_in;
   logic                             ovf_in;

   logic signed [circ_pkg::CXW-1:0]  cx_r1_ff, cy_r1_ff;
   logic [circ_pkg::MW-1:0]          magx_r1_ff, magy_r1_ff;
   logic                             ovf_r1_ff, coll_r1_ff;

   logic [circ_pkg::VW:0]            clipx_in, clipy_in;
   logic [circ_pkg::VW-1:0]          cx_r2_ff, cy_r2_ff;
   logic [2*circ_pkg::MW-1:0]        sqx_r2_ff, sqy_r2_ff;
   logic                             satc_r2_ff, ovf_r2_ff, coll_r2_ff;

   circ_pkg::root_stage_type         sq_ff [0:circ_pkg::RB];
   circ_pkg::root_stage_type         sq0_in;
   circ_pkg::root_stage_type         last;
   logic [circ_pkg::RB:0]            rnd_in;
   logic                             rclip_in;
   circ_pkg::result_type             res_in, res_ff;

   function automatic logic [circ_pkg::VW:0] clip32(input logic signed [circ_pkg::CXW-1:0] v);
      logic sat;
      sat = !((&v[circ_pkg::CXW-1:circ_pkg::VW-1]) || !(|v[circ_pkg::CXW-1:circ_pkg::VW-1]));
      if (!sat) begin
         return {1'b0, v[circ_pkg::VW-1:0]};
      end else if (v[circ_pkg::CXW-1]) begin
         return {1'b1, 1'b1, {(circ_pkg::VW-1){1'b0}}};
      end else begin
         return {1'b1, 1'b0, {(circ_pkg::VW-1){1'b1}}};
      end
   endfunction

   function automatic circ_pkg::root_stage_type root_step(input circ_pkg::root_stage_type s,
                                                          input int b);
      logic [circ_pkg::SQW-1:0] t;
      t = ({{(circ_pkg::SQW - circ_pkg::RB){1'b0}}, s.root} << (b + 1))
        | ({{(circ_pkg::SQW-1){1'b0}}, 1'b1} << (2 * b));
      if (s.rem >= t) begin
         s.rem  = s.rem - t;
         s.root = s.root | ({{(circ_pkg::RB-1){1'b0}}, 1'b1} << b);
      end
      return s;
   endfunction

   always_comb begin
      bigx_in  = in_data.big_x | in_data.q_x[circ_pkg::QB-1];
      bigy_in  = in_data.big_y | in_data.q_y[circ_pkg::QB-1];
      fullx_in = bigx_in ? {1'b1, {(circ_pkg::QB-1){1'b0}}} : in_data.q_x;
      fully_in = bigy_in ? {1'b1, {(circ_pkg::QB-1){1'b0}}} : in_data.q_y;
      ox_in    = in_data.neg_x ? -$signed({1'b0, fullx_in}) : $signed({1'b0, fullx_in});
      oy_in    = in_data.neg_y ? -$signed({1'b0, fully_in}) : $signed({1'b0, fully_in});
      cx_in    = ($signed({{(circ_pkg::CXW - circ_pkg::CW){in_data.side.x1[circ_pkg::CW-1]}},
                           in_data.side.x1}) <<< circ_pkg::FW)
               + $signed({ox_in[circ_pkg::OW-1], ox_in});
      cy_in    = ($signed({{(circ_pkg::CXW - circ_pkg::CW){in_data.side.y1[circ_pkg::CW-1]}},
                           in_data.side.y1}) <<< circ_pkg::FW)
               + $signed({oy_in[circ_pkg::OW-1], oy_in});
      ovf_in   = bigx_in | bigy_in
               | (|fullx_in[circ_pkg::QB-1:circ_pkg::MW])
               | (|fully_in[circ_pkg::QB-1:circ_pkg::MW]);
   end

   assign clipx_in = clip32(cx_r1_ff);
   assign clipy_in = clip32(cy_r1_ff);

   always_comb begin
      sq0_in.rem  = {{(circ_pkg::SQW - 2*circ_pkg::MW - 1){1'b0}}, {1'b0, sqx_r2_ff} + {1'b0, sqy_r2_ff}};
      sq0_in.root = '0;
      sq0_in.cx   = cx_r2_ff;
      sq0_in.cy   = cy_r2_ff;
      sq0_in.satc = satc_r2_ff;
      sq0_in.ovf  = ovf_r2_ff;
      sq0_in.coll = coll_r2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[NV-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cx_r1_ff   <= cx_in;
         cy_r1_ff   <= cy_in;
         magx_r1_ff <= fullx_in[circ_pkg::MW-1:0];
         magy_r1_ff <= fully_in[circ_pkg::MW-1:0];
         ovf_r1_ff  <= ovf_in;
         coll_r1_ff <= in_data.side.coll;

         cx_r2_ff   <= clipx_in[circ_pkg::VW-1:0];
         cy_r2_ff   <= clipy_in[circ_pkg::VW-1:0];
         satc_r2_ff <= clipx_in[circ_pkg::VW] | clipy_in[circ_pkg::VW];
         sqx_r2_ff  <= magx_r1_ff * magx_r1_ff;
         sqy_r2_ff  <= magy_r1_ff * magy_r1_ff;
         ovf_r2_ff  <= ovf_r1_ff;
         coll_r2_ff <= coll_r1_ff;

         sq_ff[0] <= sq0_in;
         res_ff   <= res_in;
      end
   end

   for (genvar j = 1; j <= circ_pkg::RB; j++) begin : g_sqrt
      always_ff @(posedge clock) begin
         if (en) begin
            sq_ff[j] <= root_step(sq_ff[j-1], circ_pkg::RB - j);
         end
      end
   end

   always_comb begin
      last     = sq_ff[circ_pkg::RB];
      rnd_in   = (last.rem > {{(circ_pkg::SQW - circ_pkg::RB){1'b0}}, last.root})
               ? ({1'b0, last.root} + 1'b1) : {1'b0, last.root};
      rclip_in = |rnd_in[circ_pkg::RB:circ_pkg::VW];
      if (last.coll) begin
         res_in = '0;
         res_in.collinear = 1'b1;
      end else begin
         res_in.collinear = 1'b0;
         res_in.center_x  = last.cx;
         res_in.center_y  = last.cy;
         res_in.radius    = (last.ovf | rclip_in) ? '1 : rnd_in[circ_pkg::VW-1:0];
         res_in.saturated = last.satc | last.ovf | rclip_in;
      end
   end

   assign out_valid = v_ff[NV-1];
   assign out_data  = res_ff;

endmodule

// ===== hdl/circle_through_three_points_top.sv =====
// Top level of the three-point circle pipeline: input register, stall control, result port.
// Instantiates circ_front, circ_div and circ_root; depends on circ_pkg.
//
// Usage: the req channel carries one beat per point triple, the six coordinates packed in
// req_tdata. The rsp channel returns one beat per triple in the same order: centre and
// radius in rsp_tdata, collinear and saturated flags in rsp_tuser.
// Throughput is one triple per clock cycle while the receiver does not stall. A triple
// passes the input register, circ_front, the 41 quotient stages of the divider, the 35
// stages of the square root and the result register before rsp_tvalid shows its result.
// The whole pipeline advances as one while rsp_tvalid is low or rsp_tready is high; when
// the receiver stalls, every stage holds and nothing is lost or repeated. The input
// register still takes one more beat during a stall when it is empty.
// A synchronous reset empties all stages; no result is shown after it until a new beat
// has passed through the pipeline.
module circle_through_three_points_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // first_x, first_y, second_x, second_y, third_x, third_y (16 bits each)
   input  logic [95:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // center_x, center_y, radius (32 bits each)
   output logic [95:0] rsp_tdata,
   // collinear, saturated
   output logic [1:0]  rsp_tuser
);

   logic                    en;
   logic                    in_v_ff;
   circ_pkg::point_set_type in_ff;
   logic                    front_valid, div_valid;
   circ_pkg::div_in_type    front_data;
   circ_pkg::div_out_type   div_data;
   circ_pkg::result_type    res;

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en || !in_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else if (req_tready) begin
         in_v_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_ff <= req_tdata;
      end
   end

   circ_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (in_v_ff),
      .in_pts    (in_ff),
      .out_valid (front_valid),
      .out_data  (front_data)
   );

   circ_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (front_valid),
      .in_data   (front_data),
      .out_valid (div_valid),
      .out_data  (div_data)
   );

   circ_root u_root (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (div_valid),
      .in_data   (div_data),
      .out_valid (rsp_tvalid),
      .out_data  (res)
   );

   assign rsp_tdata = {res.radius, res.center_y, res.center_x};
   assign rsp_tuser = {res.saturated, res.collinear};

endmodule

// ===== hdl/circ_checker.sv =====
// Port-level checks for circle_through_three_points_top, attached with a bind.
// Depends only on the top level's ports.
module circ_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [95:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   a_coll_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == 96'd0 && !rsp_tuser[1])
      else $error("collinear result carries data or saturation");

   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid || rsp_tready |-> req_tready)
      else $error("input stalled while output is free");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result shown right after reset");

endmodule

bind circle_through_three_points_top circ_checker u_circ_checker (.*);
